// ----- hdl/sm4_block_cipher_x4_core_assert.svh -----
// Assertion macros for the SM4 core sequencer.
`ifndef SM4_BLOCK_CIPHER_X4_CORE_ASSERT_SVH
`define SM4_BLOCK_CIPHER_X4_CORE_ASSERT_SVH

// Same-cycle implication under asynchronous active-low reset.
`define SM4_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sm4 assertion failed");

// Next-cycle implication under asynchronous active-low reset.
`define SM4_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sm4 assertion failed");

`endif

// ----- hdl/sm4_pkg.sv -----
// Shared types, constants and round function of the SM4 core.
package sm4_pkg;

  localparam int unsigned WordW       = 32;
  localparam int unsigned NumRounds   = 32;
  localparam int unsigned RoundIdxW   = $clog2(NumRounds);
  localparam int unsigned FieldLanes  = 4;
  localparam int unsigned DefaultLanes = 4;
  localparam int unsigned BlockW      = 128;
  localparam int unsigned HalfW       = 64;
  localparam int unsigned FuncW       = 2;
  localparam int unsigned BlocksW     = FieldLanes * BlockW;
  localparam int unsigned InFieldsW   = FuncW + RoundIdxW + WordW + BlocksW;
  localparam int unsigned InDataW     = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutDataW    = BlocksW;
  localparam int unsigned KeyIdxLsb   = FuncW;
  localparam int unsigned KeyWordLsb  = FuncW + RoundIdxW;
  localparam int unsigned BlocksLsb   = FuncW + RoundIdxW + WordW;

  typedef enum logic [FuncW-1:0] {
    FuncLoad = 2'd0,
    FuncEnc  = 2'd1,
    FuncDec  = 2'd2
  } sm4_func_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;  // capture the input blocks into the lane state
    logic step;  // run one round on every lane
    logic emit;  // copy the finished lanes into the output register
  } sm4_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7, 8'h16, 8'hB6, 8'h14, 8'hC2,
    8'h28, 8'hFB, 8'h2C, 8'h05, 8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
    8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99, 8'h9C, 8'h42, 8'h50, 8'hF4,
    8'h91, 8'hEF, 8'h98, 8'h7A, 8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
    8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95, 8'h80, 8'hDF, 8'h94, 8'hFA,
    8'h75, 8'h8F, 8'h3F, 8'hA6, 8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
    8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8, 8'h68, 8'h6B, 8'h81, 8'hB2,
    8'h71, 8'h64, 8'hDA, 8'h8B, 8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
    8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2, 8'h25, 8'h22, 8'h7C, 8'h3B,
    8'h01, 8'h21, 8'h78, 8'h87, 8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
    8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E, 8'hEA, 8'hBF, 8'h8A, 8'hD2,
    8'h40, 8'hC7, 8'h38, 8'hB5, 8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
    8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55, 8'hAD, 8'h93, 8'h32, 8'h30,
    8'hF5, 8'h8C, 8'hB1, 8'hE3, 8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
    8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F, 8'hD5, 8'hDB, 8'h37, 8'h45,
    8'hDE, 8'hFD, 8'h8E, 8'h2F, 8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
    8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F, 8'h11, 8'hD9, 8'h5C, 8'h41,
    8'h1F, 8'h10, 8'h5A, 8'hD8, 8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
    8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0, 8'h89, 8'h69, 8'h97, 8'h4A,
    8'h0C, 8'h96, 8'h77, 8'h7E, 8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
    8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20, 8'h79, 8'hEE, 8'h5F, 8'h3E,
    8'hD7, 8'hCB, 8'h39, 8'h48
  };

  // Byte-wise S-box substitution followed by the linear transform L.
  function automatic logic [WordW-1:0] sm4_t(input logic [WordW-1:0] x);
    logic [WordW-1:0] b;
    b = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^
           {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
  endfunction

endpackage

// ----- hdl/sm4_block_cipher_x4_core.sv -----
// Top level of the four-lane SM4 block cipher core.
//
//  Channel  Dir  Handshake              Payload
//  s_axis   in   tvalid / tready        func, key_index, key_word, four 128-bit blocks
//  m_axis   out  tvalid / tready        four 128-bit result blocks
//
// A key-load beat writes one round-key word.
// A cipher beat runs 32 rounds, one per clock, paced by the round-key RAM read,
// then hands off into the output register; the next beat is taken only once
// that hand-off is done.
// Reset clears the sequencer only; round keys are undefined until loaded.
// A result waiting on m_axis holds in the output register; the next beat is
// taken meanwhile, and the lanes stall after their last round until it drains.
module sm4_block_cipher_x4_core import sm4_pkg::*; #(
  parameter int unsigned LANES = DefaultLanes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // from low bit: func[1:0], key_index[6:2], key_word[38:7],
  // block_a_hi, block_a_lo, block_b_hi, block_b_lo,
  // block_c_hi, block_c_lo, block_d_hi, block_d_lo (64 bits each), one pad bit
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // from low bit: result_a_hi, result_a_lo, result_b_hi, result_b_lo,
  // result_c_hi, result_c_lo, result_d_hi, result_d_lo (64 bits each)
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i
);

  sm4_cmd_t             cmd;
  logic                 key_we;
  logic [RoundIdxW-1:0] key_raddr;
  logic [WordW-1:0]     key_rdata;

  // Sequence the rounds and drive the round-key addressing.
  sm4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_func_i   (s_axis_tdata_i[FuncW-1:0]),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd),
    .key_we_o    (key_we),
    .key_raddr_o (key_raddr)
  );

  // Round-key store: written by load beats, read one round ahead.
  sm4_ram #(
    .Width (WordW),
    .Depth (NumRounds)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (s_axis_tdata_i[KeyIdxLsb +: RoundIdxW]),
    .wdata_i (s_axis_tdata_i[KeyWordLsb +: WordW]),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  // Parallel lanes sharing the round key each cycle.
  sm4_dp #(
    .Lanes (LANES)
  ) u_dp (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .blocks_i (s_axis_tdata_i[BlocksLsb +: BlocksW]),
    .key_i    (key_rdata),
    .result_o (m_axis_tdata_o)
  );

endmodule

// ----- hdl/sm4_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sm4_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/sm4_ctrl.sv -----
// Sequencer of the SM4 core: handshakes, round counter and key addressing.
`include "sm4_block_cipher_x4_core_assert.svh"

module sm4_ctrl import sm4_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [FuncW-1:0]     in_func_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sm4_cmd_t             cmd_o,
  output logic                 key_we_o,
  output logic [RoundIdxW-1:0] key_raddr_o
);

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StFlush
  } state_e;

  state_e               state_q, state_d;
  logic [RoundIdxW-1:0] round_q, round_d;
  logic                 dec_q, dec_d;
  logic                 out_valid_q, out_valid_d;
  logic                 accept;
  logic                 is_cipher;
  logic                 in_dec;
  logic                 last_round;
  logic [RoundIdxW-1:0] next_idx;
  logic                 rd_dec;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign last_round = (round_q == RoundIdxW'(NumRounds - 1));

  always_comb begin
    is_cipher = 1'b0;
    in_dec    = 1'b0;
    unique case (in_func_i)
      FuncEnc: is_cipher = 1'b1;
      FuncDec: begin
        is_cipher = 1'b1;
        in_dec    = 1'b1;
      end
      default: ;
    endcase
  end

  assign key_we_o = accept && (in_func_i == FuncLoad);

  // Address the key for the round after this one; the RAM read is registered.
  always_comb begin
    if (state_q == StIdle) begin
      next_idx = '0;
      rd_dec   = in_dec;
    end else begin
      next_idx = round_q + RoundIdxW'(1);
      rd_dec   = dec_q;
    end
  end
  assign key_raddr_o = rd_dec ? ~next_idx : next_idx;

  always_comb begin
    cmd_o       = '0;
    cmd_o.load  = accept && is_cipher;
    cmd_o.step  = (state_q == StRun);
    cmd_o.emit  = (state_q == StFlush) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d     = state_q;
    round_d     = round_q;
    dec_d       = dec_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (accept && is_cipher) begin
          state_d = StRun;
          round_d = '0;
          dec_d   = in_dec;
        end
      end
      StRun: begin
        round_d = round_q + RoundIdxW'(1);
        if (last_round) begin
          state_d = StFlush;
        end
      end
      StFlush: begin
        if (cmd_o.emit) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      round_q     <= '0;
      dec_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      round_q     <= round_d;
      dec_q       <= dec_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `SM4_ASSERT_NXT(a_start_round0, clk_i, rst_ni, cmd_o.load, (state_q == StRun) && (round_q == '0))
  `SM4_ASSERT_NXT(a_last_to_flush, clk_i, rst_ni, (state_q == StRun) && last_round, state_q == StFlush)
  `SM4_ASSERT_IMP(a_emit_slot_free, clk_i, rst_ni, cmd_o.emit, !out_valid_q || out_ready_i)
  `SM4_ASSERT_IMP(a_no_write_busy, clk_i, rst_ni, key_we_o, state_q == StIdle)

endmodule

// ----- hdl/sm4_dp.sv -----
// Lane datapath of the SM4 core: round state per lane and output register.
module sm4_dp import sm4_pkg::*; #(
  parameter int unsigned Lanes = DefaultLanes
) (
  input  logic                clk_i,
  input  sm4_cmd_t            cmd_i,
  input  logic [BlocksW-1:0]  blocks_i,
  input  logic [WordW-1:0]    key_i,
  output logic [OutDataW-1:0] result_o
);

  localparam int unsigned ActiveLanes = (Lanes < FieldLanes) ? Lanes : FieldLanes;

  logic [BlocksW-1:0]  res_all;
  logic [OutDataW-1:0] out_q;

  for (genvar l = 0; l < FieldLanes; l++) begin : g_lane
    if (l < ActiveLanes) begin : g_on
      logic [3:0][WordW-1:0] w_q, w_d;
      logic [HalfW-1:0]      hi, lo;

      assign hi = blocks_i[l*BlockW +: HalfW];
      assign lo = blocks_i[l*BlockW + HalfW +: HalfW];

      // Shift the words down; the new word enters at the top.
      always_comb begin
        w_d[0] = w_q[1];
        w_d[1] = w_q[2];
        w_d[2] = w_q[3];
        w_d[3] = w_q[0] ^ sm4_t(w_q[1] ^ w_q[2] ^ w_q[3] ^ key_i);
      end

      always_ff @(posedge clk_i) begin
        if (cmd_i.load) begin
          w_q <= {lo[31:0], lo[63:32], hi[31:0], hi[63:32]};
        end else if (cmd_i.step) begin
          w_q <= w_d;
        end
      end

      // Reverse the words: hi field {w3, w2}, lo field {w1, w0}.
      assign res_all[l*BlockW +: BlockW] = {w_q[1], w_q[0], w_q[3], w_q[2]};
    end else begin : g_off
      assign res_all[l*BlockW +: BlockW] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= res_all;
    end
  end

  assign result_o = out_q;

endmodule

// ----- verif/sm4_block_cipher_x4_core_test.sv -----
// Self-checking stream testbench for the four-lane SM4 block cipher core.
module sm4_block_cipher_x4_core_test;
  import sm4_pkg::*;

  localparam int unsigned         LaneCount   = DefaultLanes;
  // Unused function code: the core drops such a beat without a result.
  localparam logic [FuncW-1:0]    FuncIdle    = 2'd3;
  localparam int unsigned         RandomBeats = 1600;
  // Give stragglers room before the verdict.
  localparam int unsigned         DrainCycles = 80;
  localparam longint unsigned     CycleLimit  = 1_000_000;

  // Field order matches the stream layout: func sits in the lowest bits.
  typedef struct packed {
    logic [BlocksW-1:0]   blocks;     // lane a hi, lane a lo, ... lane d lo
    logic [WordW-1:0]     key_word;
    logic [RoundIdxW-1:0] key_index;
    logic [FuncW-1:0]     func;
  } sm4_beat_t;

  localparam logic [7:0] SboxLut [256] = '{
    8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7, 8'h16, 8'hB6, 8'h14, 8'hC2,
    8'h28, 8'hFB, 8'h2C, 8'h05, 8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
    8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99, 8'h9C, 8'h42, 8'h50, 8'hF4,
    8'h91, 8'hEF, 8'h98, 8'h7A, 8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
    8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95, 8'h80, 8'hDF, 8'h94, 8'hFA,
    8'h75, 8'h8F, 8'h3F, 8'hA6, 8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
    8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8, 8'h68, 8'h6B, 8'h81, 8'hB2,
    8'h71, 8'h64, 8'hDA, 8'h8B, 8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
    8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2, 8'h25, 8'h22, 8'h7C, 8'h3B,
    8'h01, 8'h21, 8'h78, 8'h87, 8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
    8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E, 8'hEA, 8'hBF, 8'h8A, 8'hD2,
    8'h40, 8'hC7, 8'h38, 8'hB5, 8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
    8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55, 8'hAD, 8'h93, 8'h32, 8'h30,
    8'hF5, 8'h8C, 8'hB1, 8'hE3, 8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
    8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F, 8'hD5, 8'hDB, 8'h37, 8'h45,
    8'hDE, 8'hFD, 8'h8E, 8'h2F, 8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
    8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F, 8'h11, 8'hD9, 8'h5C, 8'h41,
    8'h1F, 8'h10, 8'h5A, 8'hD8, 8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
    8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0, 8'h89, 8'h69, 8'h97, 8'h4A,
    8'h0C, 8'h96, 8'h77, 8'h7E, 8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
    8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20, 8'h79, 8'hEE, 8'h5F, 8'h3E,
    8'hD7, 8'hCB, 8'h39, 8'h48
  };

  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;

  // Shadow copy of the round-key store and the results still owed by the core.
  logic [WordW-1:0]    round_key_copy [NumRounds];
  logic [OutDataW-1:0] pending_cipher_q [$];

  bit                  steady_flow = 1'b0;  // set: no gaps on either side
  int unsigned         error_count = 0;
  longint unsigned     cycle_count = 0;
  int unsigned         ready_hold  = 0;
  int unsigned         stall_len;
  logic [OutDataW-1:0] want_blocks;
  int unsigned         field_idx;

  sm4_block_cipher_x4_core #(
    .LANES(LaneCount)
  ) dut (
    .clk_i,
    .rst_ni,
    .s_axis_tdata_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .m_axis_tdata_o,
    .m_axis_tvalid_o,
    .m_axis_tready_i
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v, input int unsigned n);
    return (v << n) | (v >> (WordW - n));
  endfunction

  // Run all 32 rounds on every active lane with the shadow keys.
  function automatic logic [OutDataW-1:0] cipher_blocks(input logic [BlocksW-1:0] blocks,
                                                        input bit decrypt);
    logic [OutDataW-1:0] res;
    logic [WordW-1:0]    w0, w1, w2, w3, x, b, t;
    logic [BlockW-1:0]   blk;
    int unsigned         lane, r;
    res = '0;
    for (lane = 0; lane < FieldLanes; lane++) begin
      if (lane < LaneCount) begin
        blk = blocks[lane*BlockW +: BlockW];
        // hi field holds words 0 and 1, lo field words 2 and 3
        w0 = blk[HalfW-1:WordW];
        w1 = blk[WordW-1:0];
        w2 = blk[BlockW-1:HalfW+WordW];
        w3 = blk[HalfW+WordW-1:HalfW];
        for (r = 0; r < NumRounds; r++) begin
          x = w1 ^ w2 ^ w3 ^ round_key_copy[decrypt ? (NumRounds - 1 - r) : r];
          b = {SboxLut[x[31:24]], SboxLut[x[23:16]], SboxLut[x[15:8]], SboxLut[x[7:0]]};
          t = w0 ^ b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
          w0 = w1;
          w1 = w2;
          w2 = w3;
          w3 = t;
        end
        // reverse the words: hi = {w3, w2}, lo = {w1, w0}
        res[lane*BlockW +: BlockW] = {w1, w0, w3, w2};
      end
    end
    return res;
  endfunction

  function automatic int unsigned idle_length();
    int unsigned roll;
    if (steady_flow) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  function automatic logic [BlocksW-1:0] random_blocks();
    logic [BlocksW-1:0] v;
    int unsigned        i;
    for (i = 0; i < BlocksW / WordW; i++) v[i*WordW +: WordW] = $urandom;
    // now and then force one lane to all zeros or all ones
    if ($urandom_range(0, 9) == 0) begin
      i = $urandom_range(0, FieldLanes - 1);
      if ($urandom_range(0, 1) == 1) v[i*BlockW +: BlockW] = {BlockW{1'b1}};
      else v[i*BlockW +: BlockW] = '0;
    end
    return v;
  endfunction

  function automatic sm4_beat_t make_beat(input logic [FuncW-1:0] func,
                                          input logic [RoundIdxW-1:0] key_index,
                                          input logic [WordW-1:0] key_word,
                                          input logic [BlocksW-1:0] blocks);
    sm4_beat_t beat;
    beat.func      = func;
    beat.key_index = key_index;
    beat.key_word  = key_word;
    beat.blocks    = blocks;
    return beat;
  endfunction

  // Hold a gap, offer the beat, wait for the handshake, then advance the shadow state.
  task automatic send_beat(input sm4_beat_t beat);
    int unsigned gap;
    gap = idle_length();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata_i  <= InDataW'(beat);
    s_axis_tvalid_i <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    case (beat.func)
      FuncLoad: round_key_copy[beat.key_index] = beat.key_word;
      FuncEnc:  pending_cipher_q.push_back(cipher_blocks(beat.blocks, 1'b0));
      FuncDec:  pending_cipher_q.push_back(cipher_blocks(beat.blocks, 1'b1));
      default:  ;
    endcase
  endtask

  // Fill every key slot before any cipher beat reads one; extremes at both ends.
  task automatic test_key_load();
    int unsigned      i;
    logic [WordW-1:0] word;
    for (i = 0; i < NumRounds; i++) begin
      if (i == 0) word = '0;
      else if (i == NumRounds - 1) word = '1;
      else word = $urandom;
      send_beat(make_beat(FuncLoad, RoundIdxW'(i), word, '0));
    end
  endtask

  task automatic test_cipher_extremes();
    logic [BlocksW-1:0] mixed;
    mixed = {{(BlockW/WordW){32'hAAAA_AAAA}}, {(BlockW/WordW){32'h5555_5555}},
             {BlockW{1'b1}}, {BlockW{1'b0}}};
    steady_flow = 1'b1;
    send_beat(make_beat(FuncEnc, '0, '0, '0));
    send_beat(make_beat(FuncEnc, '0, '0, '1));
    send_beat(make_beat(FuncDec, '0, '0, '0));
    send_beat(make_beat(FuncDec, '0, '0, '1));
    steady_flow = 1'b0;
    send_beat(make_beat(FuncEnc, '0, '0, mixed));
    send_beat(make_beat(FuncDec, '0, '0, mixed));
  endtask

  // Fields that a beat's function does not use must have no effect.
  task automatic test_ignored_fields();
    send_beat(make_beat(FuncIdle, '1, '1, '1));
    send_beat(make_beat(FuncEnc, '0, '0, '1));
    send_beat(make_beat(FuncLoad, 5'd7, $urandom, '1));
    send_beat(make_beat(FuncEnc, '1, '1, random_blocks()));
    send_beat(make_beat(FuncDec, '1, '1, random_blocks()));
  endtask

  // Decrypting a ciphertext under the same keys must give the plaintext back.
  task automatic test_round_trip();
    logic [BlocksW-1:0] plain;
    int unsigned        n;
    for (n = 0; n < 2; n++) begin
      plain = random_blocks();
      send_beat(make_beat(FuncEnc, RoundIdxW'($urandom), $urandom, plain));
      send_beat(make_beat(FuncDec, RoundIdxW'($urandom), $urandom,
                          cipher_blocks(plain, 1'b0)));
    end
  endtask

  task automatic test_random_traffic();
    int unsigned        sent, pick, i, j, tmp;
    int unsigned        order [NumRounds];
    logic [BlocksW-1:0] plain;
    logic [WordW-1:0]   word;
    sent = 0;
    while (sent < RandomBeats) begin
      if ($urandom_range(0, 49) == 0) steady_flow = !steady_flow;
      pick = $urandom_range(0, 99);
      if (pick < 1) begin
        // rekey the whole store in shuffled order
        for (i = 0; i < NumRounds; i++) order[i] = i;
        for (i = NumRounds - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (i = 0; i < NumRounds; i++)
          send_beat(make_beat(FuncLoad, RoundIdxW'(order[i]), $urandom, random_blocks()));
        sent += NumRounds;
      end else if (pick < 12) begin
        tmp = $urandom_range(0, 9);
        if (tmp == 0) word = '0;
        else if (tmp == 1) word = '1;
        else word = $urandom;
        send_beat(make_beat(FuncLoad, RoundIdxW'($urandom_range(0, NumRounds - 1)), word,
                            random_blocks()));
        sent++;
      end else if (pick < 15) begin
        send_beat(make_beat(FuncIdle, RoundIdxW'($urandom), $urandom, random_blocks()));
      end else if (pick < 25) begin
        plain = random_blocks();
        send_beat(make_beat(FuncEnc, RoundIdxW'($urandom), $urandom, plain));
        send_beat(make_beat(FuncDec, RoundIdxW'($urandom), $urandom,
                            cipher_blocks(plain, 1'b0)));
        sent += 2;
      end else begin
        send_beat(make_beat(($urandom_range(0, 1) == 1) ? FuncDec : FuncEnc,
                            RoundIdxW'($urandom), $urandom, random_blocks()));
        sent++;
      end
    end
    steady_flow = 1'b0;
  endtask

  // Result side: alternate ready runs with stalls of random length.
  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold--;
    end else if (steady_flow || !m_axis_tready_i) begin
      m_axis_tready_i <= 1'b1;
      ready_hold = $urandom_range(0, 7);
    end else begin
      stall_len = idle_length();
      if (stall_len != 0) begin
        m_axis_tready_i <= 1'b0;
        ready_hold = stall_len - 1;
      end else begin
        ready_hold = $urandom_range(0, 7);
      end
    end
  end

  // Compare each accepted result beat, field by field, with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_cipher_q.size() == 0) begin
        $display("%0t: result beat expected none actual %h", $time, m_axis_tdata_o);
        error_count++;
      end else begin
        want_blocks = pending_cipher_q.pop_front();
        for (field_idx = 0; field_idx < 2 * FieldLanes; field_idx++) begin
          if (m_axis_tdata_o[field_idx*HalfW +: HalfW] !== want_blocks[field_idx*HalfW +: HalfW]) begin
            $display("%0t: result_%c_%s expected %h actual %h", $time,
                     8'h61 + field_idx / 2, (field_idx % 2 == 1) ? "lo" : "hi",
                     want_blocks[field_idx*HalfW +: HalfW],
                     m_axis_tdata_o[field_idx*HalfW +: HalfW]);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_key_load();
    test_cipher_extremes();
    test_ignored_fields();
    test_round_trip();
    test_random_traffic();
    s_axis_tvalid_i <= 1'b0;
    while (pending_cipher_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
